// ===== design/midi_sw_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI switcher control parser package
// Byte codes, controller numbers, parse phase codes and result word layout.
// ----------------------------------------------------------------------------
package midi_sw_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned SourceW = 9;
	localparam int unsigned PhaseW  = 3;
	localparam int unsigned BusW    = 2;
	localparam int unsigned ResultW = 32;

	// status bytes
	localparam logic [ByteW-1:0] ST_SYSEX_START = 8'hF0;
	localparam logic [ByteW-1:0] ST_SYSEX_END   = 8'hF7;
	localparam logic [ByteW-1:0] ST_CTRL_CHANGE = 8'hB0;
	localparam logic [ByteW-1:0] ST_PGM_CHANGE  = 8'hC0;

	// controller numbers
	localparam logic [ByteW-1:0] CC_BUS_SELECT = 8'h00;
	localparam logic [ByteW-1:0] CC_FADER      = 8'h12;
	localparam logic [ByteW-1:0] CC_BANK_LSB   = 8'h20;

	localparam logic [ByteW-1:0] FADER_LOW  = 8'd0;
	localparam logic [ByteW-1:0] FADER_HIGH = 8'd127;

	// parse phases
	localparam logic [PhaseW-1:0] PH_IDLE  = 3'd0;
	localparam logic [PhaseW-1:0] PH_SYSEX = 3'd1;
	localparam logic [PhaseW-1:0] PH_CCNUM = 3'd2;
	localparam logic [PhaseW-1:0] PH_CCVAL = 3'd3;
	localparam logic [PhaseW-1:0] PH_PGM   = 3'd4;

	// bus selection
	localparam logic [BusW-1:0] BUS_PROGRAM = 2'd0;
	localparam logic [BusW-1:0] BUS_PRESET  = 2'd1;
	localparam logic [BusW-1:0] BUS_NONE    = 2'd2;

	localparam logic [SourceW-1:0] PROGRAM_RESET = 9'd1;
	localparam logic [SourceW-1:0] PRESET_RESET  = 9'd2;

	typedef struct packed {
		logic [ResultW-30:0]  pad;
		logic                 unknown_status;
		logic                 program_cut;
		logic                 swapped;
		logic [ByteW-1:0]     fader_level;
		logic [SourceW-1:0]   preset_source;
		logic [SourceW-1:0]   program_source;
	} result_t;

endpackage

// ===== design/midi_switcher_control_parser_unit.sv =====
// ----------------------------------------------------------------------------
// MIDI switcher control parser
// Parses a MIDI byte stream and tracks program/preset sources of a switcher.
// ----------------------------------------------------------------------------
// Each input word is one MIDI byte; each accepted byte yields exactly one
// result word holding the program and preset source numbers, the fader level
// and three event flags, as they stand after that byte. Rate is one byte per
// clock while the consumer keeps up: the parse phase and switcher registers
// and the output result register all load at the edge that accepts a byte. The
// input stays ready while that register is empty or being drained, so a
// stalled consumer holds off only the next byte. System-exclusive bytes are
// skipped up to 0xF7, 0xB0 takes a controller number and value (controller 0
// picks the bus for program changes, 0x12 is the fader that swaps program and
// preset on reaching a new end, 0 or 127), 0xC0 takes a source byte that sets
// the selected bus to byte plus 1. Any other byte seen while idle sets the
// unknown-status flag. Argument bytes are taken whatever their value.
module midi_switcher_control_parser_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [midi_sw_pkg::ByteW-1:0]    s_tdata,   // [7:0] data_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [8:0] program_source, [17:9] preset_source, [25:18] fader_level,
	// [26] swapped, [27] program_cut, [28] unknown_status, [31:29] zero
	output logic [midi_sw_pkg::ResultW-1:0]  m_tdata
);
	import midi_sw_pkg::*;

	logic [PhaseW-1:0]  phase_q, phase_d;
	logic [ByteW-1:0]   ctrl_num_q, ctrl_num_d;
	logic [BusW-1:0]    bus_q, bus_d;
	logic [SourceW-1:0] program_q, program_d;
	logic [SourceW-1:0] preset_q, preset_d;
	logic [ByteW-1:0]   fader_q, fader_d;
	logic [ByteW-1:0]   swap_end_q, swap_end_d;
	logic               swap_d, cut_d, unknown_d;
	logic               to_low, to_high;
	logic [SourceW-1:0] new_source;

	result_t result_q;
	logic    out_valid_q;
	logic    in_acc;

	// take a byte whenever the result register is free or draining
	assign s_tready = !out_valid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;

	assign to_low     = (fader_q != FADER_LOW) && (s_tdata == FADER_LOW);
	assign to_high    = (s_tdata == FADER_HIGH) && (fader_q < FADER_HIGH);
	assign new_source = {1'b0, s_tdata} + SourceW'(1);

	// next state for one byte
	always_comb begin
		phase_d    = phase_q;
		ctrl_num_d = ctrl_num_q;
		bus_d      = bus_q;
		program_d  = program_q;
		preset_d   = preset_q;
		fader_d    = fader_q;
		swap_end_d = swap_end_q;
		swap_d     = 1'b0;
		cut_d      = 1'b0;
		unknown_d  = 1'b0;
		unique case (phase_q)
			PH_SYSEX: begin
				// skip until end of exclusive
				if (s_tdata == ST_SYSEX_END) begin
					phase_d = PH_IDLE;
				end
			end
			PH_CCNUM: begin
				ctrl_num_d = s_tdata;
				phase_d    = PH_CCVAL;
			end
			PH_CCVAL: begin
				phase_d = PH_IDLE;
				if (ctrl_num_q == CC_BUS_SELECT) begin
					if (s_tdata == 8'd0) begin
						bus_d = BUS_PROGRAM;
					end else if (s_tdata == 8'd1) begin
						bus_d = BUS_PRESET;
					end else begin
						bus_d = BUS_NONE;
					end
				end else if (ctrl_num_q == CC_FADER) begin
					// swap only on reaching a fresh end of travel
					if (s_tdata != swap_end_q && (to_low || to_high)) begin
						program_d  = preset_q;
						preset_d   = program_q;
						swap_end_d = s_tdata;
						swap_d     = 1'b1;
					end
					fader_d = s_tdata;
				end
				// bank select and other controllers: drop
			end
			PH_PGM: begin
				phase_d = PH_IDLE;
				if (bus_q == BUS_PROGRAM) begin
					program_d = new_source;
					cut_d     = 1'b1;
				end else if (bus_q == BUS_PRESET) begin
					preset_d = new_source;
				end
			end
			default: begin
				// idle, and any unused phase code behaves as idle
				phase_d = PH_IDLE;
				if (s_tdata == ST_SYSEX_START) begin
					phase_d = PH_SYSEX;
				end else if (s_tdata == ST_CTRL_CHANGE) begin
					phase_d = PH_CCNUM;
				end else if (s_tdata == ST_PGM_CHANGE) begin
					phase_d = PH_PGM;
				end else begin
					unknown_d = 1'b1;
				end
			end
		endcase
	end

	// parser and switcher state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			ctrl_num_q <= '0;
			bus_q      <= BUS_PROGRAM;
			program_q  <= PROGRAM_RESET;
			preset_q   <= PRESET_RESET;
			fader_q    <= '0;
			swap_end_q <= '0;
		end else if (in_acc) begin
			phase_q    <= phase_d;
			ctrl_num_q <= ctrl_num_d;
			bus_q      <= bus_d;
			program_q  <= program_d;
			preset_q   <= preset_d;
			fader_q    <= fader_d;
			swap_end_q <= swap_end_d;
		end
	end

	// result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	// result register: payload, loaded with the state after this byte
	always_ff @(posedge clk) begin
		if (in_acc) begin
			result_q.pad            <= '0;
			result_q.unknown_status <= unknown_d;
			result_q.program_cut    <= cut_d;
			result_q.swapped        <= swap_d;
			result_q.fader_level    <= fader_d;
			result_q.preset_source  <= preset_d;
			result_q.program_source <= program_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = result_q;

	// at most one event flag per result word
	a_flags_onehot0: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0({result_q.swapped, result_q.program_cut,
			result_q.unknown_status}))
		else $error("more than one event flag in a result word");

	// a swap exchanges the two sources
	a_swap_exchanges: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && swap_d |=> program_q == $past(preset_q) && preset_q == $past(program_q))
		else $error("swap did not exchange program and preset");

	// a cut loads program with the byte plus one
	a_cut_value: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && cut_d |=> program_q == {1'b0, $past(s_tdata)} + SourceW'(1))
		else $error("program cut loaded a wrong source");

	// exclusive start in idle enters the skip phase
	a_sysex_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && phase_q == PH_IDLE && s_tdata == ST_SYSEX_START |=> phase_q == PH_SYSEX)
		else $error("sysex start did not enter skip phase");

endmodule

// ===== bench/midi_switcher_control_parser_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI switcher control parser testbench
// Drives MIDI bytes into the parser and checks every result word against a
// local model of the switcher. A short directed list comes first, then random
// well-formed messages mixed with noise under three idling mixes. Both stream
// sides throttle at random, and the output side also holds off for a long
// stretch once.
// ----------------------------------------------------------------------------
module midi_switcher_control_parser_unit_test;
	import midi_sw_pkg::*;

	localparam int DirRows        = 29;
	localparam int BytesPerPhase  = 583;
	localparam int LongStallLen   = 300;
	localparam int DrainCycles    = 8;

	// one directed byte; the expected word is typed in only where typed is set
	typedef struct packed {
		logic [ByteW-1:0]   data;
		logic               typed;
		logic [SourceW-1:0] prog;
		logic [SourceW-1:0] pre;
		logic [ByteW-1:0]   fader;
		logic               swp;
		logic               cut;
		logic               unk;
	} midi_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [ByteW-1:0]     s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [ResultW-1:0]   m_tdata;

	// local copy of the switcher state
	logic [PhaseW-1:0]    sw_phase;
	logic [ByteW-1:0]     sw_ctrl;
	logic [BusW-1:0]      sw_bus;
	logic [SourceW-1:0]   sw_program;
	logic [SourceW-1:0]   sw_preset;
	logic [ByteW-1:0]     sw_fader;
	logic [ByteW-1:0]     sw_swap_end;

	result_t switcher_states_due [$];

	int send_idle_pct;
	int recv_idle_pct;
	bit want_stall;
	int bytes_sent;
	int results_checked;
	int error_count;
	int swaps_seen;
	int cuts_seen;
	int unknown_seen;

	midi_row_t directed_rows [DirRows] = '{
		// stray sysex end and the top byte while idle: both unknown
		'{ST_SYSEX_END,   1, PROGRAM_RESET, PRESET_RESET, FADER_LOW, 0, 0, 1},
		'{8'hFF,          1, PROGRAM_RESET, PRESET_RESET, FADER_LOW, 0, 0, 1},
		// status byte inside sysex is skipped
		'{ST_SYSEX_START, 0, 0, 0, 0, 0, 0, 0},
		'{ST_CTRL_CHANGE, 0, 0, 0, 0, 0, 0, 0},
		'{ST_SYSEX_END,   0, 0, 0, 0, 0, 0, 0},
		// fader to the top end, then back to the bottom: two swaps
		'{ST_CTRL_CHANGE, 0, 0, 0, 0, 0, 0, 0},
		'{CC_FADER,       0, 0, 0, 0, 0, 0, 0},
		'{FADER_HIGH,     1, PRESET_RESET, PROGRAM_RESET, FADER_HIGH, 1, 0, 0},
		'{ST_CTRL_CHANGE, 0, 0, 0, 0, 0, 0, 0},
		'{CC_FADER,       0, 0, 0, 0, 0, 0, 0},
		'{FADER_LOW,      1, PROGRAM_RESET, PRESET_RESET, FADER_LOW, 1, 0, 0},
		// fader above the range: stored, no swap
		'{ST_CTRL_CHANGE, 0, 0, 0, 0, 0, 0, 0},
		'{CC_FADER,       0, 0, 0, 0, 0, 0, 0},
		'{8'hFF,          0, 0, 0, 0, 0, 0, 0},
		// program change with the top byte lands on source 256
		'{ST_PGM_CHANGE,  0, 0, 0, 0, 0, 0, 0},
		'{8'hFF,          1, 9'd256, PRESET_RESET, 8'hFF, 0, 1, 0},
		// select the preset bus and set it to source 1
		'{ST_CTRL_CHANGE, 0, 0, 0, 0, 0, 0, 0},
		'{CC_BUS_SELECT,  0, 0, 0, 0, 0, 0, 0},
		'{8'(BUS_PRESET), 0, 0, 0, 0, 0, 0, 0},
		'{ST_PGM_CHANGE,  0, 0, 0, 0, 0, 0, 0},
		'{8'h00,          0, 0, 0, 0, 0, 0, 0},
		// odd bus value: later program changes hit neither bus
		'{ST_CTRL_CHANGE, 0, 0, 0, 0, 0, 0, 0},
		'{CC_BUS_SELECT,  0, 0, 0, 0, 0, 0, 0},
		'{8'h05,          0, 0, 0, 0, 0, 0, 0},
		'{ST_PGM_CHANGE,  0, 0, 0, 0, 0, 0, 0},
		'{8'h40,          0, 0, 0, 0, 0, 0, 0},
		// ignored controller with a status byte as its value
		'{ST_CTRL_CHANGE, 0, 0, 0, 0, 0, 0, 0},
		'{CC_BANK_LSB,    0, 0, 0, 0, 0, 0, 0},
		'{ST_PGM_CHANGE,  0, 0, 0, 0, 0, 0, 0}
	};

	midi_switcher_control_parser_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard limit, far above the slowest legal run.
	initial begin
		#2_000_000;
		$display("midi_switcher_control_parser_unit_test failed");
		$finish;
	end

	// Return to the reset state of the switcher.
	task automatic reset_switcher_model();
		sw_phase    = PH_IDLE;
		sw_ctrl     = CC_BUS_SELECT;
		sw_bus      = BUS_PROGRAM;
		sw_program  = PROGRAM_RESET;
		sw_preset   = PRESET_RESET;
		sw_fader    = FADER_LOW;
		sw_swap_end = FADER_LOW;
	endtask

	// Apply one byte to the local switcher state and return the word it yields.
	function automatic result_t advance_switcher(input logic [ByteW-1:0] b);
		result_t          r;
		logic             did_swap;
		logic             did_cut;
		logic             unk;
		logic [SourceW-1:0] held;
		did_swap = 1'b0;
		did_cut  = 1'b0;
		unk      = 1'b0;
		case (sw_phase)
			PH_SYSEX: begin
				if (b == ST_SYSEX_END)
					sw_phase = PH_IDLE;
			end
			PH_CCNUM: begin
				sw_ctrl  = b;
				sw_phase = PH_CCVAL;
			end
			PH_CCVAL: begin
				sw_phase = PH_IDLE;
				if (sw_ctrl == CC_BUS_SELECT) begin
					if (b == 8'(BUS_PROGRAM))
						sw_bus = BUS_PROGRAM;
					else if (b == 8'(BUS_PRESET))
						sw_bus = BUS_PRESET;
					else
						sw_bus = BUS_NONE;
				end else if (sw_ctrl == CC_FADER) begin
					// swap only on reaching an end from the other side, and a new end
					if (b != sw_swap_end &&
					    ((sw_fader > FADER_LOW && b == FADER_LOW) ||
					     (b == FADER_HIGH && sw_fader < FADER_HIGH))) begin
						held        = sw_program;
						sw_program  = sw_preset;
						sw_preset   = held;
						sw_swap_end = b;
						did_swap    = 1'b1;
					end
					sw_fader = b;
				end
			end
			PH_PGM: begin
				sw_phase = PH_IDLE;
				if (sw_bus == BUS_PROGRAM) begin
					sw_program = {1'b0, b} + 9'd1;
					did_cut    = 1'b1;
				end else if (sw_bus == BUS_PRESET) begin
					sw_preset = {1'b0, b} + 9'd1;
				end
			end
			default: begin
				sw_phase = PH_IDLE;
				if (b == ST_SYSEX_START)
					sw_phase = PH_SYSEX;
				else if (b == ST_CTRL_CHANGE)
					sw_phase = PH_CCNUM;
				else if (b == ST_PGM_CHANGE)
					sw_phase = PH_PGM;
				else
					unk = 1'b1;
			end
		endcase
		r                = '0;
		r.program_source = sw_program;
		r.preset_source  = sw_preset;
		r.fader_level    = sw_fader;
		r.swapped        = did_swap;
		r.program_cut    = did_cut;
		r.unknown_status = unk;
		return r;
	endfunction

	task automatic flag_mismatch(input int idx, input string what,
	                             input logic [31:0] got, input logic [31:0] want);
		$display("MISMATCH word %0d %s: got 0x%0h, want 0x%0h", idx, what, got, want);
		error_count++;
	endtask

	// Offer one byte, with random idle cycles ahead of it. Enter and leave at a
	// falling edge so valid is written once per time step.
	task automatic offer_byte(input logic [ByteW-1:0] b, input logic typed,
	                          input result_t typed_want);
		result_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do begin
			@(posedge clk);
		end while (s_tready !== 1'b1);
		predicted = advance_switcher(b);
		switcher_states_due.push_back(typed ? typed_want : predicted);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Mostly complete messages with random content; the rest is loose bytes.
	task automatic offer_random_message();
		int               kind;
		int               pick;
		int               len;
		logic [ByteW-1:0] v;
		kind = $urandom_range(0, 99);
		pick = $urandom_range(0, 99);
		if (kind < 30) begin
			// fader: lean on both ends so swaps keep happening
			if (pick < 35)
				v = FADER_LOW;
			else if (pick < 70)
				v = FADER_HIGH;
			else if (pick < 85)
				v = 8'($urandom_range(1, 126));
			else
				v = 8'($urandom_range(128, 255));
			offer_byte(ST_CTRL_CHANGE, 1'b0, '0);
			offer_byte(CC_FADER, 1'b0, '0);
			offer_byte(v, 1'b0, '0);
		end else if (kind < 45) begin
			if (pick < 40)
				v = 8'(BUS_PROGRAM);
			else if (pick < 75)
				v = 8'(BUS_PRESET);
			else
				v = 8'($urandom_range(0, 255));
			offer_byte(ST_CTRL_CHANGE, 1'b0, '0);
			offer_byte(CC_BUS_SELECT, 1'b0, '0);
			offer_byte(v, 1'b0, '0);
		end else if (kind < 55) begin
			v = (pick < 50) ? CC_BANK_LSB : 8'($urandom_range(0, 255));
			offer_byte(ST_CTRL_CHANGE, 1'b0, '0);
			offer_byte(v, 1'b0, '0);
			offer_byte(8'($urandom_range(0, 255)), 1'b0, '0);
		end else if (kind < 75) begin
			offer_byte(ST_PGM_CHANGE, 1'b0, '0);
			offer_byte(8'($urandom_range(0, 255)), 1'b0, '0);
		end else if (kind < 87) begin
			// sysex body: mostly data bytes, now and then any byte at all
			len = $urandom_range(0, 5);
			offer_byte(ST_SYSEX_START, 1'b0, '0);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 99) < 15)
					v = 8'($urandom_range(0, 255));
				else
					v = 8'($urandom_range(0, 127));
				offer_byte(v, 1'b0, '0);
			end
			offer_byte(ST_SYSEX_END, 1'b0, '0);
		end else begin
			offer_byte(8'($urandom_range(0, 255)), 1'b0, '0);
		end
	endtask

	// Drop valid and hold until every expected word has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		wait (switcher_states_due.size() == 0);
		@(negedge clk);
	endtask

	// Output side: random ready, or a long hold-off when one is requested.
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (want_stall) begin
				stall_left = LongStallLen;
				want_stall = 1'b0;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Check each accepted result word against the oldest expectation.
	initial begin
		result_t got;
		result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid === 1'b1 && m_tready === 1'b1) begin
				got = m_tdata;
				if (switcher_states_due.size() == 0) begin
					flag_mismatch(results_checked, "unexpected word", m_tdata, 32'd0);
				end else begin
					want = switcher_states_due.pop_front();
					if (got.program_source !== want.program_source)
						flag_mismatch(results_checked, "program_source",
						              32'(got.program_source),
						              32'(want.program_source));
					if (got.preset_source !== want.preset_source)
						flag_mismatch(results_checked, "preset_source",
						              32'(got.preset_source),
						              32'(want.preset_source));
					if (got.fader_level !== want.fader_level)
						flag_mismatch(results_checked, "fader_level",
						              32'(got.fader_level), 32'(want.fader_level));
					if (got.swapped !== want.swapped)
						flag_mismatch(results_checked, "swapped",
						              32'(got.swapped), 32'(want.swapped));
					if (got.program_cut !== want.program_cut)
						flag_mismatch(results_checked, "program_cut",
						              32'(got.program_cut), 32'(want.program_cut));
					if (got.unknown_status !== want.unknown_status)
						flag_mismatch(results_checked, "unknown_status",
						              32'(got.unknown_status),
						              32'(want.unknown_status));
					if (got.pad !== want.pad)
						flag_mismatch(results_checked, "pad bits",
						              32'(got.pad), 32'(want.pad));
					swaps_seen   += want.swapped;
					cuts_seen    += want.program_cut;
					unknown_seen += want.unknown_status;
				end
				results_checked++;
			end
		end
	end

	// Stimulus: reset, directed list, then three idling mixes of random traffic.
	initial begin
		result_t   row_want;
		midi_row_t row;
		int        phase_start;
		bit        stall_done;
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		want_stall      = 1'b0;
		bytes_sent      = 0;
		results_checked = 0;
		error_count     = 0;
		swaps_seen      = 0;
		cuts_seen       = 0;
		unknown_seen    = 0;
		stall_done      = 1'b0;
		send_idle_pct   = 26;
		recv_idle_pct   = 81;
		reset_switcher_model();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed list, under the first idling mix
		for (int i = 0; i < DirRows; i++) begin
			row                     = directed_rows[i];
			row_want                = '0;
			row_want.program_source = row.prog;
			row_want.preset_source  = row.pre;
			row_want.fader_level    = row.fader;
			row_want.swapped        = row.swp;
			row_want.program_cut    = row.cut;
			row_want.unknown_status = row.unk;
			offer_byte(row.data, row.typed, row_want);
		end
		drain_results();

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle_pct = 26;
					recv_idle_pct = 81;
				end
				1: begin
					send_idle_pct = 81;
					recv_idle_pct = 26;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < BytesPerPhase) begin
				// with no idling at all, hold the output off once so the input backs up
				if (p == 2 && !stall_done && bytes_sent - phase_start >= 100) begin
					want_stall = 1'b1;
					stall_done = 1'b1;
				end
				offer_random_message();
			end
			drain_results();
		end

		// watch for stray words past the last expected one
		repeat (DrainCycles) @(posedge clk);
		while (switcher_states_due.size() != 0) begin
			flag_mismatch(results_checked, "missing word", 32'd0,
			              switcher_states_due.pop_front());
		end

		$display("Covered %0d bytes (%0d directed) and checked %0d result words,",
		         bytes_sent, DirRows, results_checked);
		$display("  with %0d swaps, %0d program cuts, %0d unknown status bytes.",
		         swaps_seen, cuts_seen, unknown_seen);
		if (error_count == 0) begin
			$display("midi_switcher_control_parser_unit_test passed");
		end else begin
			$display("midi_switcher_control_parser_unit_test failed");
		end
		$finish;
	end

endmodule
